FILE: src/ale_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_pkg: shared types and codes for the array list engine
// Action and status codes, controller states and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ale_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_REPLACE  = 3'd2,
    ACT_RETRIEVE = 3'd3,
    ACT_SEARCH   = 3'd4,
    ACT_SORT     = 3'd5,
    ACT_RSVD6    = 3'd6,
    ACT_RSVD7    = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_REM_MOVE,
    S_SRCH,
    S_SRCH_CMP,
    S_SRT_OUTER,
    S_SRT_SCAN,
    S_SRT_SWAP,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the input transaction
    logic rd_en;        // read memory at rd_sel address
    logic [2:0] rd_sel; // address source for the read
    logic wr_en;        // write memory
    logic [2:0] wr_sel; // address/data source for the write
    logic ptr_load;     // load pointer for walk
    logic ptr_step;     // step pointer
    logic cnt_inc;
    logic cnt_dec;
    logic set_status;
    logic [1:0] status_val;
    logic set_rd;       // latch read data into the working result
    logic clr_result;
    logic set_found;    // latch pointer as found index
    logic best_load;    // best = ptr, best value = read data
    logic i_load;       // sort outer index = 0
    logic i_step;
    logic res_valid_set;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    pos_gt_cnt;
    logic    pos_ge_cnt;
    logic    full;
    logic    ptr_done;   // walk has reached its end
    logic    match;      // registered read data equals search value
    logic    less;       // registered read data below best value, or first scan
    logic    i_done;     // sort outer loop complete
    logic    res_busy;   // result still waiting
  } stat_t;

  localparam logic [2:0] SEL_PTR  = 3'd0;
  localparam logic [2:0] SEL_PTRM = 3'd1; // pointer minus one / write data is rdata
  localparam logic [2:0] SEL_POS  = 3'd2;
  localparam logic [2:0] SEL_BEST = 3'd3; // best slot takes the saved entry i
  localparam logic [2:0] SEL_I    = 3'd4;
  localparam logic [2:0] SEL_PTRP = 3'd5;

endpackage

FILE: src/array_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine: ordered list of signed words in an on-chip memory
// Top level joining the controller and datapath.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and gives one result. Insert and remove
// shift entries one at a time through the entry memory, a read and then a
// write per moved entry; search reads and compares one entry at a time, and
// sort is a selection sort that scans the rest for its minimum on each pass.
// A finished result waits in the controller until
// the output register is free, so a stalled result holds up the next one.
// The entry memory has no reset pass; the count clears at reset.
module array_list_engine #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic [6:0]         found_index,
  output logic [7:0]         entry_count,
  output logic [1:0]         status,
  output logic               is_empty,
  output logic               is_full
);
  import ale_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  cmd_t  cmd;
  stat_t stat;
  logic  busy;
  logic  in_fire;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;

  ale_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .stat(stat), .cmd(cmd), .busy(busy)
  );

  ale_dp #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .action(action), .position(position), .value(value),
    .out_stall(out_stall), .out_valid(out_valid),
    .read_value(read_value), .found_index(found_index),
    .entry_count(entry_count), .status(status),
    .is_empty(is_empty), .is_full(is_full)
  );
endmodule

FILE: src/ale_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_ctrl: controller for the array list engine
// Sequences each action over the entry memory with at most one read or one
// write per cycle; insert, remove, search and sort walk a pointer over it.
// ----------------------------------------------------------------------------
module ale_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  ale_pkg::stat_t stat,
  output ale_pkg::cmd_t  cmd,
  output logic           busy
);
  import ale_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.clr_result = 1'b1;
        cmd.status_val = ST_OK;
        cmd.set_status = 1'b1;
        state_next = S_RESULT;
        unique case (stat.action)
          ACT_INSERT: begin
            if (stat.pos_gt_cnt) cmd.status_val = ST_BADPOS;
            else if (stat.full) cmd.status_val = ST_FULL;
            else begin
              // Walk from the top entry down to the position.
              cmd.ptr_load = 1'b1;
              state_next = S_INS_RD;
            end
          end
          ACT_REMOVE: begin
            if (stat.pos_ge_cnt) cmd.status_val = ST_BADPOS;
            else begin
              cmd.ptr_load = 1'b1;
              cmd.rd_en = 1'b1;
              cmd.rd_sel = SEL_POS;
              state_next = S_REM_RD;
            end
          end
          ACT_REPLACE: begin
            if (stat.pos_ge_cnt) cmd.status_val = ST_BADPOS;
            else begin
              cmd.wr_en = 1'b1;
              cmd.wr_sel = SEL_POS;
            end
          end
          ACT_RETRIEVE: begin
            if (stat.pos_ge_cnt) cmd.status_val = ST_BADPOS;
            else begin
              cmd.rd_en = 1'b1;
              cmd.rd_sel = SEL_POS;
              state_next = S_REM_RD;
            end
          end
          ACT_SEARCH: begin
            cmd.status_val = ST_NOTFOUND;
            cmd.ptr_load = 1'b1;
            state_next = S_SRCH;
          end
          ACT_SORT: begin
            cmd.i_load = 1'b1;
            state_next = S_SRT_OUTER;
          end
          default: ;
        endcase
      end
      S_INS_RD: begin
        // ptr is the destination; position reached means write the new value.
        if (stat.ptr_done) begin
          cmd.wr_en = 1'b1;
          cmd.wr_sel = SEL_POS;
          cmd.cnt_inc = 1'b1;
          state_next = S_RESULT;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = SEL_PTRM;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = SEL_PTR;
        cmd.ptr_step = 1'b1;
        state_next = S_INS_RD;
      end
      S_REM_RD: begin
        // The entry at the position is now registered.
        cmd.set_rd = 1'b1;
        state_next = (stat.action == ACT_REMOVE) ? S_REM_WR : S_RESULT;
      end
      S_REM_WR: begin
        if (stat.ptr_done) begin
          cmd.cnt_dec = 1'b1;
          state_next = S_RESULT;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = SEL_PTRP;
          state_next = S_REM_MOVE;
        end
      end
      S_REM_MOVE: begin
        // Remove shift: write entry ptr+1 into ptr, then advance.
        cmd.wr_en = 1'b1;
        cmd.wr_sel = SEL_PTR;
        cmd.ptr_step = 1'b1;
        state_next = S_REM_WR;
      end
      S_SRCH: begin
        if (stat.ptr_done) state_next = S_RESULT;
        else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = SEL_PTR;
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          cmd.set_found = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_val = ST_OK;
          state_next = S_RESULT;
        end else begin
          cmd.ptr_step = 1'b1;
          state_next = S_SRCH;
        end
      end
      S_SRT_OUTER: begin
        if (stat.i_done) state_next = S_RESULT;
        else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = SEL_I;
          cmd.ptr_load = 1'b1;
          state_next = S_SRT_SCAN;
        end
      end
      S_SRT_SCAN: begin
        // ptr walks j; registered data belongs to ptr (first: i).
        if (stat.less) cmd.best_load = 1'b1;
        if (stat.ptr_done) begin
          // Entry i takes the minimum now; the old entry i moves to the
          // minimum's slot in the next cycle.
          cmd.wr_en = 1'b1;
          cmd.wr_sel = SEL_I;
          state_next = S_SRT_SWAP;
        end else begin
          cmd.ptr_step = 1'b1;
          cmd.rd_en = 1'b1;
          cmd.rd_sel = SEL_PTRP;
        end
      end
      S_SRT_SWAP: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = SEL_BEST;
        cmd.i_step = 1'b1;
        state_next = S_SRT_OUTER;
      end
      S_RESULT: begin
        if (!stat.res_busy) begin
          cmd.res_valid_set = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.cnt_inc && cmd.cnt_dec)) else $error("count inc and dec together");
  a_idle_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> state == S_IDLE) else $error("capture outside idle");
  a_cap_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_DECODE) else $error("no decode after capture");
endmodule

FILE: src/ale_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_dp: datapath for the array list engine
// Entry memory, count, walk pointers and the result register.
// ----------------------------------------------------------------------------
module ale_dp #(
  parameter int CAPACITY = 128,
  parameter int AW = 7,
  parameter int CW = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ale_pkg::cmd_t         cmd,
  output ale_pkg::stat_t        stat,
  input  logic [2:0]            action,
  input  logic [7:0]            position,
  input  logic signed [31:0]    value,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic signed [31:0]    read_value,
  output logic [6:0]            found_index,
  output logic [7:0]            entry_count,
  output logic [1:0]            status,
  output logic                  is_empty,
  output logic                  is_full
);
  import ale_pkg::*;

  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata;
  logic [2:0]    act_q;
  logic [CW-1:0] pos_q;
  logic [31:0]   val_q;
  logic [CW-1:0] cnt, ptr, i_idx, best;
  logic [31:0]   best_val;
  logic [31:0]   iv;
  logic          scan_first;
  logic [CW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;
  logic [31:0]   rd_w;
  logic [6:0]    found_w;
  logic [1:0]    status_w;
  logic [15:0]   posq_w, cnt_w;
  logic          pos_gt, pos_ge;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= action;
      val_q  <= value;
      posq_w <= 16'(position);
    end
  end

  // Position is up to 8 bits wide; compare both at 16 bits.
  assign cnt_w  = 16'(cnt);
  assign pos_gt = posq_w > cnt_w;
  assign pos_ge = posq_w >= cnt_w;
  assign pos_q  = posq_w[CW-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      SEL_PTRM: rd_addr = ptr - 1'b1;
      SEL_POS:  rd_addr = pos_q;
      SEL_I:    rd_addr = i_idx;
      SEL_PTRP: rd_addr = ptr + 1'b1;
      default:  rd_addr = ptr;
    endcase
  end

  // A sort swap takes two writes: entry i gets the minimum when the scan
  // ends, and the best slot gets the saved entry i in the cycle after.
  always_comb begin
    unique case (cmd.wr_sel)
      SEL_POS: begin
        wr_addr = pos_q;
        wr_data = val_q;
      end
      SEL_I: begin
        wr_addr = i_idx;
        wr_data = (stat.less) ? rdata : best_val;
      end
      SEL_BEST: begin
        wr_addr = best;
        wr_data = iv;
      end
      default: begin
        wr_addr = ptr;
        wr_data = rdata;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
    if (cmd.rd_en) rdata <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      if (cmd.cnt_inc) cnt <= cnt + 1'b1;
      else if (cmd.cnt_dec) cnt <= cnt - 1'b1;
    end
  end

  // Walk pointer and sort indices.
  always_ff @(posedge clk) begin
    if (cmd.i_load) i_idx <= '0;
    else if (cmd.i_step) i_idx <= i_idx + 1'b1;
    if (cmd.ptr_load) begin
      unique case (act_q)
        ACT_INSERT: ptr <= cnt;
        ACT_REMOVE: ptr <= pos_q;
        ACT_SORT:   ptr <= i_idx;
        default:    ptr <= '0;
      endcase
    end else if (cmd.ptr_step) begin
      ptr <= (act_q == ACT_INSERT) ? ptr - 1'b1 : ptr + 1'b1;
    end
    if (cmd.ptr_load) scan_first <= 1'b1;
    else if (cmd.ptr_step || cmd.wr_en) scan_first <= 1'b0;
    if (cmd.best_load) begin
      best <= ptr;
      best_val <= rdata;
    end
    // The first scan cycle of a sort pass holds entry i.
    if (cmd.best_load && scan_first) iv <= rdata;
  end

  always_comb begin
    stat.action     = action_t'(act_q);
    stat.pos_gt_cnt = pos_gt;
    stat.pos_ge_cnt = pos_ge;
    stat.full       = (cnt >= CAP);
    stat.match      = (rdata == val_q);
    stat.less       = scan_first ||
                      ($signed(rdata) < $signed(best_val));
    stat.i_done     = (CW+1)'(i_idx) + 1'b1 >= (CW+1)'(cnt);
    stat.res_busy   = out_valid;
    unique case (act_q)
      ACT_INSERT: stat.ptr_done = (ptr == pos_q);
      ACT_REMOVE: stat.ptr_done = (CW+1)'(ptr) + 1'b1 >= (CW+1)'(cnt);
      ACT_SORT:   stat.ptr_done = (CW+1)'(ptr) + 1'b1 >= (CW+1)'(cnt);
      default:    stat.ptr_done = (ptr >= cnt);
    endcase
  end

  // Working result, built while the previous result may still be waiting.
  always_ff @(posedge clk) begin
    if (cmd.clr_result) begin
      rd_w    <= '0;
      found_w <= '0;
    end
    if (cmd.set_rd) rd_w <= rdata;
    if (cmd.set_found) found_w <= 7'(ptr);
    if (cmd.set_status) status_w <= cmd.status_val;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.res_valid_set) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (cmd.res_valid_set) begin
      read_value  <= rd_w;
      found_index <= found_w;
      entry_count <= 8'(cnt);
      status      <= status_w;
      is_empty    <= (cnt == '0);
      is_full     <= (cnt >= CAP);
    end
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP) else $error("count above capacity");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_inc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> cnt < CAP) else $error("insert into full list");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(read_value) && $stable(entry_count))
    else $error("stalled result changed");
endmodule
